// File: sv/clnorm_pkg.sv
// Shared constants and types of the clause literal normaliser.
`default_nettype none
package clnorm_pkg;

    localparam int MAX_LITS  = 64;
    localparam int VAR_BITS  = 24;
    localparam int KEY_BITS  = VAR_BITS + 1;
    localparam int VAR_W     = 24;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_LITERAL   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TAUTOLOGY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/clnorm_cell.sv
// One cell of the sorted literal chain: holds one key and its valid bit.
`default_nettype none
module clnorm_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire clnorm_pkg::cell_ctrl_t ctrl,
    input  wire clnorm_pkg::key_t    new_key,
    input  wire logic                left_cond,
    input  wire logic                left_valid,
    input  wire clnorm_pkg::key_t    left_key,
    input  wire logic                right_valid,
    input  wire clnorm_pkg::key_t    right_key,
    output logic                     valid,
    output clnorm_pkg::key_t         key,
    output logic                     cond,
    output logic                     match,
    output logic                     comp
);
    import clnorm_pkg::*;

    logic valid_reg;
    logic valid_next;
    key_t key_reg;
    key_t key_next;

    // cond: the new key belongs at this cell or further left
    assign cond  = !valid_reg || (key_reg > new_key);
    assign match = valid_reg && (key_reg == new_key);
    assign comp  = valid_reg && (key_reg == (new_key ^ key_t'(1)));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = right_valid;
            key_next   = right_key;
        end
        else if (ctrl.insert)
        begin
            if (left_cond)
            begin
                valid_next = left_valid;
                key_next   = left_key;
            end
            else if (cond)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;

endmodule
`default_nettype wire

// File: sv/clnorm_chain.sv
// Row of sorted cells with duplicate and complement detection.
`default_nettype none
module clnorm_chain (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire clnorm_pkg::cell_ctrl_t ctrl,
    input  wire clnorm_pkg::key_t       new_key,
    output logic                        match_any,
    output logic                        comp_any,
    output logic                        full,
    output logic                        head_valid,
    output clnorm_pkg::key_t            head_key,
    output logic                        second_valid
);
    import clnorm_pkg::*;

    logic [MAX_LITS-1:0] valid_v;
    logic [MAX_LITS-1:0] cond_v;
    logic [MAX_LITS-1:0] match_v;
    logic [MAX_LITS-1:0] comp_v;
    key_t                key_v [MAX_LITS];

    for (genvar i = 0; i < MAX_LITS; i++)
    begin : g_cell
        logic left_cond;
        logic left_valid;
        key_t left_key;
        logic right_valid;
        key_t right_key;

        if (i == 0)
        begin : g_first
            assign left_cond  = 1'b0;
            assign left_valid = 1'b0;
            assign left_key   = new_key;
        end
        else
        begin : g_inner_l
            assign left_cond  = cond_v[i-1];
            assign left_valid = valid_v[i-1];
            assign left_key   = key_v[i-1];
        end

        if (i == MAX_LITS - 1)
        begin : g_last
            assign right_valid = 1'b0;
            assign right_key   = new_key;
        end
        else
        begin : g_inner_r
            assign right_valid = valid_v[i+1];
            assign right_key   = key_v[i+1];
        end

        clnorm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .left_cond   (left_cond),
            .left_valid  (left_valid),
            .left_key    (left_key),
            .right_valid (right_valid),
            .right_key   (right_key),
            .valid       (valid_v[i]),
            .key         (key_v[i]),
            .cond        (cond_v[i]),
            .match       (match_v[i]),
            .comp        (comp_v[i])
        );
    end

    assign match_any    = |match_v;
    assign comp_any     = |comp_v;
    assign full         = valid_v[MAX_LITS-1];
    assign head_valid   = valid_v[0];
    assign head_key     = key_v[0];
    assign second_valid = valid_v[1];

endmodule
`default_nettype wire

// File: sv/clause_literal_normalizer_top.sv
// Top level of the clause literal normaliser: control, flags and result register.
`default_nettype none
// Channel  Handshake               Payload
// in       in_valid / in_ready     lit_var, lit_positive, clause_end
// out      out_valid / out_ready   out_var, out_positive, out_last, status
//
// Each literal item is inserted straight into the sorted cell row as it is taken,
// so a clause streams in at one literal per cycle.
// After the item marked clause_end, the row drains from its head at one result
// per cycle while out_ready allows it (or as one status result) while input is
// held off; input reopens in the cycle after the last drain step.
// Reset empties the row and clears both flags at once; output stalls simply
// pause the drain.
module clause_literal_normalizer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [clnorm_pkg::VAR_W-1:0]     lit_var,
    input  wire logic                             lit_positive,
    input  wire logic                             clause_end,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [clnorm_pkg::VAR_W-1:0]          out_var,
    output logic                                  out_positive,
    output logic                                  out_last,
    output logic [clnorm_pkg::STATUS_W-1:0]       status
);
    import clnorm_pkg::*;

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_DRAIN  = 1'b1;

    logic       state_reg;
    logic       state_next;
    logic       taut_reg;
    logic       taut_next;
    logic       ovf_reg;
    logic       ovf_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [VAR_W-1:0]    out_var_reg;
    logic [VAR_W-1:0]    out_var_next;
    logic                out_pos_reg;
    logic                out_pos_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    key_t       new_key;
    cell_ctrl_t ctrl;
    logic       in_fire;
    logic       match_any;
    logic       comp_any;
    logic       full;
    logic       head_valid;
    key_t       head_key;
    logic       second_valid;
    logic       out_free;
    logic       drain_step;
    logic       flag_result;

    // Key: variable above, polarity in the low bit (negated sorts first)
    assign new_key = {lit_var[VAR_BITS-1:0], lit_positive};

    assign in_ready    = (state_reg == ST_ACCEPT);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign drain_step  = (state_reg == ST_DRAIN) && out_free;
    assign flag_result = taut_reg || ovf_reg;

    // Drop duplicates; a complement marks a tautology; a full row marks overflow
    assign ctrl.insert = in_fire && !match_any && !comp_any && !full;
    assign ctrl.shift  = drain_step && !flag_result;
    assign ctrl.clear  = drain_step && flag_result;

    clnorm_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_key      (new_key),
        .match_any    (match_any),
        .comp_any     (comp_any),
        .full         (full),
        .head_valid   (head_valid),
        .head_key     (head_key),
        .second_valid (second_valid)
    );

    always_comb
    begin
        state_next     = state_reg;
        taut_next      = taut_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_var_next   = out_var_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        status_next    = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire && !match_any)
        begin
            if (comp_any)
            begin
                taut_next = 1'b1;
            end
            else if (full)
            begin
                ovf_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (in_fire && clause_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_step)
                begin
                    if (flag_result)
                    begin
                        // One status item replaces the list; tautology wins
                        out_valid_next = 1'b1;
                        out_var_next   = '0;
                        out_pos_next   = 1'b0;
                        out_last_next  = 1'b1;
                        status_next    = taut_reg ? STATUS_TAUTOLOGY : STATUS_OVERFLOW;
                        taut_next      = 1'b0;
                        ovf_next       = 1'b0;
                        state_next     = ST_ACCEPT;
                    end
                    else
                    begin
                        if (head_valid)
                        begin
                            out_valid_next = 1'b1;
                            out_var_next   = VAR_W'(head_key[KEY_BITS-1:1]);
                            out_pos_next   = head_key[0];
                            out_last_next  = !second_valid;
                            status_next    = STATUS_LITERAL;
                        end
                        if (!second_valid)
                        begin
                            state_next = ST_ACCEPT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            taut_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            taut_reg      <= taut_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload; no reset needed
    always_ff @(posedge clk)
    begin
        out_var_reg  <= out_var_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
        status_reg   <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_var      = out_var_reg;
    assign out_positive = out_pos_reg;
    assign out_last     = out_last_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

// File: sim/clnorm_clause_checker.sv
// Clause checker for the clause literal normaliser: predicts each clause's results and compares.
module clnorm_clause_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic [clnorm_pkg::VAR_W-1:0]    lit_var,
    input  wire logic                            lit_positive,
    input  wire logic                            clause_end,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [clnorm_pkg::VAR_W-1:0]    out_var,
    input  wire logic                            out_positive,
    input  wire logic                            out_last,
    input  wire logic [clnorm_pkg::STATUS_W-1:0] status,
    output int                                   mismatch_count,
    output int                                   pending_results
);
    import clnorm_pkg::*;

    typedef struct packed {
        logic [VAR_W-1:0]    lit;
        logic                positive;
        logic                last;
        logic [STATUS_W-1:0] status;
    } clause_out_t;

    clause_out_t expected_lits[$];
    clause_out_t want;

    // Own copy of the sorted literal row and the clause flags
    key_t lit_store[MAX_LITS];
    int   stored_count = 0;
    bit   taut_seen    = 1'b0;
    bit   ovf_seen     = 1'b0;

    function automatic bit store_has(input key_t k);
        for (int i = 0; i < stored_count; i++)
            if (lit_store[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    // Insert one literal in key order; drop duplicates, flag complements and a full row
    task automatic absorb_literal(input key_t k);
        int slot;
        if (store_has(k))
            return;
        if (store_has(k ^ key_t'(1)))
        begin
            taut_seen = 1'b1;
            return;
        end
        if (stored_count >= MAX_LITS)
        begin
            ovf_seen = 1'b1;
            return;
        end
        slot = stored_count;
        while (slot > 0 && lit_store[slot-1] > k)
        begin
            lit_store[slot] = lit_store[slot-1];
            slot--;
        end
        lit_store[slot] = k;
        stored_count++;
    endtask

    // Emit either the sorted literals or one status result, then clear the clause
    task automatic close_clause();
        clause_out_t r;
        if (taut_seen || ovf_seen)
        begin
            r.lit      = '0;
            r.positive = 1'b0;
            r.last     = 1'b1;
            r.status   = taut_seen ? STATUS_TAUTOLOGY : STATUS_OVERFLOW;
            expected_lits.push_back(r);
        end
        else
        begin
            for (int i = 0; i < stored_count; i++)
            begin
                r.lit      = VAR_W'(lit_store[i][KEY_BITS-1:1]);
                r.positive = lit_store[i][0];
                r.last     = (i == stored_count - 1);
                r.status   = STATUS_LITERAL;
                expected_lits.push_back(r);
            end
        end
        stored_count = 0;
        taut_seen    = 1'b0;
        ovf_seen     = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_literal({lit_var[VAR_BITS-1:0], lit_positive});
                if (clause_end)
                    close_clause();
            end
            if (out_valid && out_ready)
            begin
                if (expected_lits.size() == 0)
                begin
                    $error("unexpected result: out_var=%0h out_positive=%0b out_last=%0b %s%0d",
                           out_var, out_positive, out_last, "status=", status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_lits.pop_front();
                    if (out_var !== want.lit)
                    begin
                        $error("out_var: expected %0h, got %0h", want.lit, out_var);
                        mismatch_count++;
                    end
                    if (out_positive !== want.positive)
                    begin
                        $error("out_positive: expected %0b, got %0b",
                               want.positive, out_positive);
                        mismatch_count++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", want.last, out_last);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                end
            end
            pending_results = expected_lits.size();
        end
    end

endmodule

// File: sim/tb.sv
// Testbench top for the clause literal normaliser: clock, reset, stimulus, output pacing and verdict.
module tb;
    import clnorm_pkg::*;

    // Ways to finish a clause that has filled the whole literal row
    typedef enum int {
        WIDE_DUP_END,       // full row, closed by a duplicate: every literal comes back
        WIDE_TAUT_WINS,     // one literal dropped, then a complement of a stored one
        WIDE_MISSED_COMPL   // one literal dropped, then its own complement
    } wide_tail_e;

    localparam int TOTAL_ITEMS  = 230;     // least number of literal items sent, directed and random
    localparam int LONG_HOLD    = 200;     // cycles the receiver holds off under pressure
    localparam int DRAIN_GUARD  = 2 * MAX_LITS + 16;
    localparam int CYCLE_LIMIT  = 200000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [VAR_W-1:0]    lit_var;
    logic                lit_positive;
    logic                clause_end;
    logic                out_valid;
    logic                out_ready;
    logic [VAR_W-1:0]    out_var;
    logic                out_positive;
    logic                out_last;
    logic [STATUS_W-1:0] status;

    int mismatch_count;
    int pending_results;
    int cycle_count   = 0;
    int items_sent    = 0;
    bit send_calm     = 1'b0;   // clause-wide: offer items back to back
    bit long_hold_req = 1'b0;   // raised by the stimulus, taken up once by the receiver

    clause_literal_normalizer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .lit_var      (lit_var),
        .lit_positive (lit_positive),
        .clause_end   (clause_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_var      (out_var),
        .out_positive (out_positive),
        .out_last     (out_last),
        .status       (status)
    );

    clnorm_clause_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .lit_var         (lit_var),
        .lit_positive    (lit_positive),
        .clause_end      (clause_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_var         (out_var),
        .out_positive    (out_positive),
        .out_last        (out_last),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: give up well beyond the slowest legal run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Idle cycles before the next item: mostly none, some short, a few long
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Variable numbers biased towards the extremes and a small range that collides often
    function automatic logic [VAR_W-1:0] pick_var();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return {VAR_W{1'b1}};
        if (r < 6)
            return VAR_W'($urandom_range(0, 15));
        return VAR_W'($urandom);
    endfunction

    // Offer one literal item and hold it until the block takes it.
    // Entered and left just after a falling edge; valid drops only when a gap follows.
    task automatic send_literal(input logic [VAR_W-1:0] v, input logic p, input logic e);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        lit_var      <= v;
        lit_positive <= p;
        clause_end   <= e;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Fill the row with MAX_LITS distinct variables (odd stride keeps them apart),
    // then close the clause in one of the ways that touch the full-row cases
    task automatic send_wide_clause(input wide_tail_e tail);
        logic [VAR_W-1:0] base;
        logic [VAR_W-1:0] stride;
        logic [VAR_W-1:0] spare;
        logic             wide_pol [MAX_LITS];
        logic             spare_pol;
        int               pick;
        base      = VAR_W'($urandom);
        stride    = VAR_W'($urandom) | VAR_W'(1);
        spare     = base + VAR_W'(MAX_LITS) * stride;
        spare_pol = $urandom_range(0, 1);
        pick      = $urandom_range(0, MAX_LITS - 1);
        for (int i = 0; i < MAX_LITS; i++)
        begin
            wide_pol[i] = $urandom_range(0, 1);
            send_literal(base + VAR_W'(i) * stride, wide_pol[i], 1'b0);
        end
        case (tail)
            WIDE_DUP_END:
                send_literal(base + VAR_W'(pick) * stride, wide_pol[pick], 1'b1);
            WIDE_TAUT_WINS:
            begin
                send_literal(spare, spare_pol, 1'b0);
                send_literal(base + VAR_W'(pick) * stride, !wide_pol[pick], 1'b1);
            end
            default:
            begin
                send_literal(spare, spare_pol, 1'b0);
                send_literal(spare, !spare_pol, 1'b1);
            end
        endcase
    endtask

    // Stimulus: reset, directed clauses, full-row clauses, then random clauses
    initial
    begin
        logic [VAR_W-1:0] pool_var [6];
        logic             pool_pol [6];
        int               pool_size;
        int               n_lits;
        int               j;
        bit               mixed;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        lit_var      = '0;
        lit_positive = 1'b0;
        clause_end   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-literal clauses at both ends of the variable range
        send_literal('0, 1'b0, 1'b1);
        send_literal({VAR_W{1'b1}}, 1'b1, 1'b1);

        // Sorting and duplicates: out of order, repeated, alternating bit patterns
        send_literal(24'd5, 1'b1, 1'b0);
        send_literal(24'd3, 1'b0, 1'b0);
        send_literal(24'd5, 1'b1, 1'b0);
        send_literal({VAR_W{1'b1}}, 1'b0, 1'b0);
        send_literal(24'd3, 1'b0, 1'b0);
        send_literal('0, 1'b1, 1'b0);
        send_literal(24'hAAAAAA, 1'b1, 1'b0);
        send_literal(24'h555555, 1'b0, 1'b1);

        // Tautology, with the complement arriving mid-clause and a duplicate after it
        send_literal(24'd9, 1'b1, 1'b0);
        send_literal(24'd2, 1'b0, 1'b0);
        send_literal(24'd9, 1'b0, 1'b0);
        send_literal(24'd2, 1'b0, 1'b1);

        // Same variable both ways, then the stored polarity again as the end
        send_literal(24'd7, 1'b0, 1'b0);
        send_literal(24'd7, 1'b1, 1'b0);
        send_literal(24'd7, 1'b0, 1'b1);

        // A clause of one literal given twice
        send_literal(24'd4, 1'b1, 1'b0);
        send_literal(24'd4, 1'b1, 1'b1);

        // Full row closed by a duplicate; then hold off the receiver while the
        // next wide clause is offered, so the drain stalls and input backs up
        send_wide_clause(WIDE_DUP_END);
        long_hold_req = 1'b1;
        send_calm     = 1'b1;
        send_wide_clause(WIDE_TAUT_WINS);
        send_calm     = 1'b0;
        send_wide_clause(WIDE_MISSED_COMPL);

        // Random clauses over a small per-clause pool of variables; most keep one
        // polarity per variable, the rest mix them and tend to tautologies
        while (items_sent < TOTAL_ITEMS)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            mixed     = ($urandom_range(0, 3) == 0);
            pool_size = $urandom_range(1, 6);
            for (int k = 0; k < pool_size; k++)
            begin
                pool_var[k] = pick_var();
                pool_pol[k] = $urandom_range(0, 1);
            end
            n_lits = $urandom_range(1, 10);
            for (int k = 0; k < n_lits; k++)
            begin
                j = $urandom_range(0, pool_size - 1);
                send_literal(pool_var[j],
                             mixed ? 1'($urandom_range(0, 1)) : pool_pol[j],
                             k == n_lits - 1);
            end
        end
        in_valid <= 1'b0;

        // Let every predicted result arrive, then watch for strays
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_GUARD) @(posedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: phases of steady acceptance alternate with choppy stalls;
    // a long hold-off is taken up once the stimulus asks for one
    initial
    begin
        int  stall_left;
        int  phase_left;
        int  r;
        bit  calm;
        bit  hold_taken;

        out_ready  = 1'b0;
        stall_left = 0;
        phase_left = 0;
        calm       = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                phase_left--;
                if (phase_left <= 0)
                begin
                    calm       = ($urandom_range(0, 3) == 0);
                    phase_left = $urandom_range(20, 100);
                end
                r = $urandom_range(0, 99);
                if (calm || r < 70)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready  <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(8, 30);
                end
            end
        end
    end

endmodule

// File: filelist.f
sv/clnorm_pkg.sv
sv/clnorm_cell.sv
sv/clnorm_chain.sv
sv/clause_literal_normalizer_top.sv
sim/clnorm_clause_checker.sv
sim/tb.sv
